// ===== rtl/tpm_pkg.sv =====
`default_nettype none

package tpm_pkg;

  localparam int TABLE_FRAMES_DEF = 16;
  localparam int NUM_ENTRIES      = 1024;
  localparam int IDX_W            = 10;

  localparam logic [19:0] BASE_FRAME_RST = 20'd256;
  localparam logic [IDX_W-1:0] IDX_LAST  = '1;

  // present | writable
  localparam logic [11:0] ENT_LOW_PW = 12'h003;

  typedef enum logic {
    OP_MAP  = 1'b0,
    OP_INIT = 1'b1
  } tpm_op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_INIT  = 2'd1,
    ST_NO_FRAMES = 2'd2
  } tpm_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIR_CLR,
    S_MAP_RD,
    S_MAP_EVAL,
    S_ALLOC,
    S_FILL,
    S_DONE
  } tpm_state_e;

  typedef struct packed {
    logic        opcode;
    logic [31:0] vaddr;
    logic [31:0] paddr;
    logic [11:0] flags;
    logic [31:0] map_limit;
  } tpm_in_t;

  typedef struct packed {
    tpm_status_e status;
    logic [31:0] dir_entry;
    logic [31:0] table_entry;
    logic        new_table;
    logic [20:0] pages_mapped;
  } tpm_out_t;

  typedef struct packed {
    logic             we;
    logic             re;
    logic [IDX_W-1:0] addr;
    logic [31:0]      wdata;
  } dir_req_t;

endpackage

`default_nettype wire

// ===== rtl/tpm_dir_mem.sv =====
`default_nettype none

module tpm_dir_mem
  import tpm_pkg::*;
(
  input  wire logic     clk_i,
  input  wire dir_req_t req_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem [NUM_ENTRIES];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/tpm_tbl_mem.sv =====
`default_nettype none

module tpm_tbl_mem
  import tpm_pkg::*;
#(
  parameter int TABLE_FRAMES = TABLE_FRAMES_DEF,
  localparam int TAW = $clog2(TABLE_FRAMES * NUM_ENTRIES)
) (
  input  wire logic           clk_i,
  input  wire logic           we_i,
  input  wire logic [TAW-1:0] addr_i,
  input  wire logic [31:0]    wdata_i
);

  // Page tables live here; the mapper itself only writes, and there is no read port.
  logic [31:0] mem [TABLE_FRAMES * NUM_ENTRIES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tpm_ctrl.sv =====
`default_nettype none

module tpm_ctrl
  import tpm_pkg::*;
#(
  parameter int TABLE_FRAMES = TABLE_FRAMES_DEF,
  localparam int TAW = $clog2(TABLE_FRAMES * NUM_ENTRIES),
  localparam int KW  = (TABLE_FRAMES > 1) ? $clog2(TABLE_FRAMES) : 1,
  localparam int FUW = $clog2(TABLE_FRAMES + 1)
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire tpm_in_t        in_data_i,
  output logic                busy_o,
  input  wire logic [19:0]    base_frame_i,
  output logic                res_valid_o,
  input  wire logic           res_ready_i,
  output tpm_out_t            res_o,
  output dir_req_t            dir_req_o,
  input  wire logic [31:0]    dir_rdata_i,
  output logic                tbl_we_o,
  output logic [TAW-1:0]      tbl_addr_o,
  output logic [31:0]         tbl_wdata_o
);

  tpm_state_e state_q, state_d;
  logic initialized_q, initialized_d;
  logic [FUW-1:0] frames_used_q, frames_used_d;

  logic op_init_q, op_init_d;
  logic [IDX_W-1:0] dir_idx_q, dir_idx_d;
  logic [IDX_W-1:0] ti_q, ti_d;
  logic [IDX_W-1:0] sweep_q, sweep_d;
  logic [KW-1:0] k_q, k_d;
  logic [20:0] npages_q, npages_d;
  logic [31:0] te_hold_q, te_hold_d;

  tpm_status_e status_q, status_d;
  logic [31:0] de_q, de_d;
  logic [31:0] te_q, te_d;
  logic new_q, new_d;
  logic [20:0] pages_q, pages_d;

  logic [19:0] k_map;
  logic [19:0] fill_page;
  logic fill_hit;
  logic [31:0] fill_te;
  logic [20:0] next_base;
  logic tbl_full;
  logic [32:0] lim_sum;
  logic [KW+IDX_W-1:0] fill_addr_w;
  logic [KW+IDX_W-1:0] map_addr_w;

  assign k_map       = dir_rdata_i[31:12] - base_frame_i - 20'd1;
  assign fill_page   = {dir_idx_q, sweep_q};
  assign fill_hit    = op_init_q ? ({1'b0, fill_page} < npages_q) : (sweep_q == ti_q);
  assign fill_te     = op_init_q ? {fill_page, ENT_LOW_PW} : te_hold_q;
  assign next_base   = {1'b0, dir_idx_q, {IDX_W{1'b0}}} + 21'(NUM_ENTRIES);
  assign tbl_full    = (frames_used_q >= FUW'(TABLE_FRAMES));
  assign lim_sum     = {1'b0, in_data_i.map_limit} + 33'h0_0000_0FFF;
  assign fill_addr_w = {k_q, sweep_q};
  assign map_addr_w  = {k_map[KW-1:0], ti_q};

  always_comb begin
    state_d       = state_q;
    initialized_d = initialized_q;
    frames_used_d = frames_used_q;
    op_init_d     = op_init_q;
    dir_idx_d     = dir_idx_q;
    ti_d          = ti_q;
    sweep_d       = sweep_q;
    k_d           = k_q;
    npages_d      = npages_q;
    te_hold_d     = te_hold_q;
    status_d      = status_q;
    de_d          = de_q;
    te_d          = te_q;
    new_d         = new_q;
    pages_d       = pages_q;
    dir_req_o     = '0;
    tbl_we_o      = 1'b0;
    tbl_addr_o    = '0;
    tbl_wdata_o   = '0;
    res_valid_o   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          status_d  = ST_OK;
          de_d      = '0;
          te_d      = '0;
          new_d     = 1'b0;
          pages_d   = '0;
          op_init_d = (in_data_i.opcode == OP_INIT);
          if (in_data_i.opcode == OP_INIT) begin
            npages_d      = lim_sum[32:12];
            dir_idx_d     = '0;
            sweep_d       = '0;
            initialized_d = 1'b1;
            frames_used_d = '0;
            state_d       = S_DIR_CLR;
          end else if (!initialized_q) begin
            status_d = ST_NOT_INIT;
            state_d  = S_DONE;
          end else begin
            dir_idx_d = in_data_i.vaddr[31:22];
            ti_d      = in_data_i.vaddr[21:12];
            te_hold_d = {in_data_i.paddr[31:12], in_data_i.flags[11:1], 1'b1};
            state_d   = S_MAP_RD;
          end
        end
      end
      S_DIR_CLR: begin
        dir_req_o.we   = 1'b1;
        dir_req_o.addr = sweep_q;
        sweep_d        = sweep_q + 1'b1;
        if (sweep_q == IDX_LAST) begin
          state_d = (npages_q == '0) ? S_DONE : S_ALLOC;
        end
      end
      S_MAP_RD: begin
        dir_req_o.re   = 1'b1;
        dir_req_o.addr = dir_idx_q;
        state_d        = S_MAP_EVAL;
      end
      S_MAP_EVAL: begin
        if (dir_rdata_i[0]) begin
          // drop the write if the entry names a frame outside the live pool
          if (k_map < 20'(frames_used_q)) begin
            tbl_we_o    = 1'b1;
            tbl_addr_o  = map_addr_w[TAW-1:0];
            tbl_wdata_o = te_hold_q;
          end
          de_d    = dir_rdata_i;
          te_d    = te_hold_q;
          pages_d = 21'd1;
          state_d = S_DONE;
        end else if (tbl_full) begin
          status_d = ST_NO_FRAMES;
          de_d     = dir_rdata_i;
          state_d  = S_DONE;
        end else begin
          state_d = S_ALLOC;
        end
      end
      S_ALLOC: begin
        if (tbl_full) begin
          status_d = ST_NO_FRAMES;
          state_d  = S_DONE;
        end else begin
          dir_req_o.we    = 1'b1;
          dir_req_o.addr  = dir_idx_q;
          dir_req_o.wdata = {base_frame_i + 20'(frames_used_q) + 20'd1, ENT_LOW_PW};
          de_d            = {base_frame_i + 20'(frames_used_q) + 20'd1, ENT_LOW_PW};
          new_d           = 1'b1;
          k_d             = frames_used_q[KW-1:0];
          frames_used_d   = frames_used_q + 1'b1;
          sweep_d         = '0;
          state_d         = S_FILL;
        end
      end
      S_FILL: begin
        tbl_we_o    = 1'b1;
        tbl_addr_o  = fill_addr_w[TAW-1:0];
        tbl_wdata_o = fill_hit ? fill_te : '0;
        if (fill_hit) begin
          te_d    = fill_te;
          pages_d = pages_q + 21'd1;
        end
        sweep_d = sweep_q + 1'b1;
        if (sweep_q == IDX_LAST) begin
          if (op_init_q && (next_base < npages_q)) begin
            dir_idx_d = dir_idx_q + 1'b1;
            state_d   = S_ALLOC;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      initialized_q <= 1'b0;
      frames_used_q <= '0;
    end else begin
      state_q       <= state_d;
      initialized_q <= initialized_d;
      frames_used_q <= frames_used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_init_q <= op_init_d;
    dir_idx_q <= dir_idx_d;
    ti_q      <= ti_d;
    sweep_q   <= sweep_d;
    k_q       <= k_d;
    npages_q  <= npages_d;
    te_hold_q <= te_hold_d;
    status_q  <= status_d;
    de_q      <= de_d;
    te_q      <= te_d;
    new_q     <= new_d;
    pages_q   <= pages_d;
  end

  assign busy_o             = (state_q != S_IDLE);
  assign res_o.status       = status_q;
  assign res_o.dir_entry    = de_q;
  assign res_o.table_entry  = te_q;
  assign res_o.new_table    = new_q;
  assign res_o.pages_mapped = pages_q;

endmodule

`default_nettype wire

// ===== rtl/two_level_page_table_mapper_top.sv =====
// A map to a present directory entry reads it, then writes the table entry;
//   a map to an absent entry allocates and fills a table, one entry written per cycle.
// Init clears the directory, then allocates and fills tables until the map limit is covered.
// One item at a time; the next is taken once the last result enters the output register.
// Reset clears control state, the allocator and the initialized flag; directory
//   and table memories hold garbage until written. No clearing pass follows reset.
`default_nettype none

module two_level_page_table_mapper_top
  import tpm_pkg::*;
#(
  parameter int TABLE_FRAMES = TABLE_FRAMES_DEF,
  localparam int TAW = $clog2(TABLE_FRAMES * NUM_ENTRIES)
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire tpm_in_t     in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output tpm_out_t         out_data_o,
  input  wire logic        cfg_we_i,
  input  wire logic [19:0] cfg_wdata_i
);

  logic [19:0] base_frame_q;

  logic        busy;
  logic        res_valid;
  logic        res_ready;
  tpm_out_t    res;
  dir_req_t    dir_req;
  logic [31:0] dir_rdata;
  logic        tbl_we;
  logic [TAW-1:0] tbl_addr;
  logic [31:0] tbl_wdata;

  logic     out_valid_q;
  tpm_out_t out_q;

  // Pool base register: directory frame, tables follow it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_frame_q <= BASE_FRAME_RST;
    end else if (cfg_we_i) begin
      base_frame_q <= cfg_wdata_i;
    end
  end

  tpm_ctrl #(
    .TABLE_FRAMES(TABLE_FRAMES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .busy_o      (busy),
    .base_frame_i(base_frame_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .dir_req_o   (dir_req),
    .dir_rdata_i (dir_rdata),
    .tbl_we_o    (tbl_we),
    .tbl_addr_o  (tbl_addr),
    .tbl_wdata_o (tbl_wdata)
  );

  tpm_dir_mem u_dir_mem (
    .clk_i  (clk_i),
    .req_i  (dir_req),
    .rdata_o(dir_rdata)
  );

  tpm_tbl_mem #(
    .TABLE_FRAMES(TABLE_FRAMES)
  ) u_tbl_mem (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .addr_i (tbl_addr),
    .wdata_i(tbl_wdata)
  );

  // Take a new input transfer only when the sequencer is idle.
  assign in_stall_o = busy;

  // Output register: load when empty or draining; a stalled result holds the
  // sequencer in its done state and so holds up the next item.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // An accepted transfer makes the sequencer busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted but sequencer not busy");

  // A map before init reports nothing written and no table.
  a_not_init_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status == ST_NOT_INIT)) |->
      ((out_data_o.pages_mapped == '0) && !out_data_o.new_table))
    else $error("not-initialized result carries mapping data");

  // Whenever a table was allocated, the reported directory entry is present and writable.
  a_alloc_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.new_table) |-> (out_data_o.dir_entry[1:0] == 2'b11))
    else $error("allocated table with non-present directory entry");

  // Results only come out of the sequencer when the output register can hold them.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !(res_valid && res_ready))
    else $error("pending result overwritten");

endmodule

`default_nettype wire
